[src/tbpw_pkg.sv]
// Package with shared types and constants of the tensor-to-BGR pixel writer.
package tbpw_pkg;

  localparam int ADDR_W       = 26;
  localparam int RAW_W        = 32;
  localparam int DIM_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd1024;

  // Element type codes.
  typedef enum logic [1:0] {
    ET_FLOAT32 = 2'd0,
    ET_FLOAT16 = 2'd1,
    ET_UINT8   = 2'd2,
    ET_INT8    = 2'd3
  } elem_type_e;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_LAST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  typedef struct packed {
    elem_type_e       element_type;
    logic             channel_last;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        pixel_byte;
    logic              frame_end;
  } pix_t;

endpackage

[src/tbpw_elem_if.sv]
// Input channel interface carrying one tensor element per item.
interface tbpw_elem_if import tbpw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_element;

  modport source (output valid, output raw_element, input ready);
  modport sink   (input valid, input raw_element, output ready);
endinterface

[src/tbpw_pix_if.sv]
// Output channel interface carrying one addressed pixel byte per item.
interface tbpw_pix_if import tbpw_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/tbpw_cfg_if.sv]
// Configuration write channel interface.
interface tbpw_cfg_if import tbpw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[src/tbpw_byte_cvt.sv]
// Element-to-byte converter for float32, float16, uint8 and int8 elements.
module tbpw_byte_cvt import tbpw_pkg::*; (
  input  elem_type_e       elem_type_i,
  input  logic [RAW_W-1:0] raw_i,
  output logic [7:0]       byte_o
);

  logic        h_nan, h_zero;
  logic [31:0] h_wide, fbits;
  logic        f_force_zero;
  logic [7:0]  f_byte;

  // Widen a half to single precision; subnormal halves scale to zero anyway.
  always_comb begin
    h_nan  = 1'b0;
    h_zero = 1'b0;
    h_wide = 32'd0;
    if (raw_i[14:10] == 5'h1F) begin
      h_nan  = (raw_i[9:0] != 10'd0);
      h_wide = {raw_i[15], 8'hFF, 23'd0};
    end else if (raw_i[14:10] == 5'd0) begin
      h_zero = 1'b1;
    end else begin
      h_wide = {raw_i[15], 8'(raw_i[14:10]) + 8'd112, raw_i[9:0], 13'd0};
    end
  end

  always_comb begin
    fbits        = (elem_type_i == ET_FLOAT16) ? h_wide : raw_i;
    f_force_zero = (elem_type_i == ET_FLOAT16) && (h_nan || h_zero);
  end

  // Float path: scale by 255 when in [0,1], round like a float32 product,
  // then clamp and round half away from zero.
  always_comb begin
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] mm;
    logic [31:0] x;
    logic [24:0] r;
    logic [7:0]  sh;
    logic [25:0] sum26;
    logic [24:0] sum25;
    logic [25:0] q26;
    logic [24:0] q25;
    s  = fbits[31];
    e  = fbits[30:23];
    m  = fbits[22:0];
    mm = {1'b1, m};
    x  = {mm, 8'd0} - {8'd0, mm};
    r  = 25'd0;
    sh = 8'd0;
    sum26 = 26'd0;
    sum25 = 25'd0;
    q26 = 26'd0;
    q25 = 25'd0;
    f_byte = 8'd0;
    if (e == 8'hFF) begin
      f_byte = (m == 23'd0 && !s) ? 8'd255 : 8'd0;
    end else if (s || e == 8'd0) begin
      f_byte = 8'd0;
    end else if (e < 8'd127 || (e == 8'd127 && m == 23'd0)) begin
      // Product rounded to 24 significant bits, nearest even.
      if (x[31]) begin
        r  = {1'b0, x[31:8]} + 25'(x[7] && (x[8] || (x[6:0] != 7'd0)));
        sh = 8'd142 - e;
      end else begin
        r  = {1'b0, x[30:7]} + 25'(x[6] && (x[7] || (x[5:0] != 6'd0)));
        sh = 8'd143 - e;
      end
      if (sh <= 8'd25) begin
        sum26 = {1'b0, r} + (26'd1 << (sh - 8'd1));
        q26   = sum26 >> sh;
        f_byte = (q26 > 26'd255) ? 8'd255 : q26[7:0];
      end
    end else if (e >= 8'd135) begin
      f_byte = 8'd255;
    end else begin
      sh    = 8'd150 - e;
      sum25 = {1'b0, mm} + (25'd1 << (sh - 8'd1));
      q25   = sum25 >> sh;
      f_byte = (q25 > 25'd255) ? 8'd255 : q25[7:0];
    end
  end

  // Select by element type.
  always_comb begin
    case (elem_type_i)
      ET_FLOAT32: byte_o = f_byte;
      ET_FLOAT16: byte_o = f_force_zero ? 8'd0 : f_byte;
      ET_UINT8:   byte_o = raw_i[7:0];
      ET_INT8:    byte_o = raw_i[7] ? 8'd0 : raw_i[7:0];
      default:    byte_o = 8'd0;
    endcase
  end

endmodule

[src/tbpw_pos_ctr.sv]
// Position counters that track column, row and channel of each element.
module tbpw_pos_ctr import tbpw_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          step_i,
  output logic [CW-1:0] col_o,
  output logic [RW-1:0] row_o,
  output logic [1:0]    chan_o,
  output logic          last_o,
  output logic [CW:0]   width_o
);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [1:0]    chan_q, chan_d;
  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;
  logic          col_wrap, row_wrap, chan_wrap;

  // Effective dimensions: zero reads as one, large values saturate.
  always_comb begin
    if (cfg_i.image_width == '0) w_eff = (CW+1)'(1);
    else if (32'(cfg_i.image_width) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(cfg_i.image_width);
    if (cfg_i.image_height == '0) h_eff = (RW+1)'(1);
    else if (32'(cfg_i.image_height) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
    else h_eff = (RW+1)'(cfg_i.image_height);
  end

  assign col_wrap  = {1'b0, col_q} >= (w_eff - (CW+1)'(1));
  assign row_wrap  = {1'b0, row_q} >= (h_eff - (RW+1)'(1));
  assign chan_wrap = chan_q >= 2'd2;

  // Advance in tensor memory order.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    chan_d = chan_q;
    last_o = 1'b0;
    if (cfg_i.channel_last) begin
      if (chan_wrap) begin
        chan_d = 2'd0;
        if (col_wrap) begin
          col_d = '0;
          if (row_wrap) begin
            row_d  = '0;
            last_o = 1'b1;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end else begin
        chan_d = chan_q + 2'd1;
      end
    end else begin
      if (col_wrap) begin
        col_d = '0;
        if (row_wrap) begin
          row_d = '0;
          if (chan_wrap) begin
            chan_d = 2'd0;
            last_o = 1'b1;
          end else begin
            chan_d = chan_q + 2'd1;
          end
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= 2'd0;
    end else if (step_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      chan_q <= chan_d;
    end
  end

  assign col_o   = col_q;
  assign row_o   = row_q;
  assign chan_o  = chan_q;
  assign width_o = w_eff;

endmodule

[src/tensor_to_bgr_pixel_writer.sv]
// Top level of the tensor-to-BGR pixel writer: config, input and result registers.
// An accepted element is stored in the input register; its byte and address are then
// registered in the result register, which drives the output channel.
// Throughput: one element per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result is not taken.
// Reset clears the position counters, the pipeline valid bits and the configuration
// registers (float32, planar order, 1024 by 1024). Configuration writes are always accepted.
module tensor_to_bgr_pixel_writer import tbpw_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tbpw_cfg_if.sink    cfg_if,
  tbpw_elem_if.sink   in_if,
  tbpw_pix_if.source  out_if
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = CW + RW + 4;
  localparam int SW = (PW > ADDR_W) ? PW : ADDR_W;

  cfg_t cfg_q;

  logic          in_fire, b_ready, a_load;
  logic          a_vld_q, b_vld_q;
  logic [RAW_W-1:0] a_raw_q;
  logic [CW-1:0] a_col_q, pos_col;
  logic [RW-1:0] a_row_q, pos_row;
  logic [1:0]    a_chan_q, pos_chan;
  logic          a_last_q, pos_last;
  logic [CW:0]   w_eff;
  logic [7:0]    cvt_byte;
  logic [SW-1:0] pix_idx, addr_full;
  pix_t          b_data_q;

  // Configuration registers, always ready.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.element_type <= ET_FLOAT32;
      cfg_q.channel_last <= 1'b0;
      cfg_q.image_width  <= DIM_RESET;
      cfg_q.image_height <= DIM_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_ELEMENT_TYPE: cfg_q.element_type <= elem_type_e'(cfg_if.wdata[1:0]);
        REG_CHANNEL_LAST: cfg_q.channel_last <= cfg_if.wdata[0];
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_if.wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_if.wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake of the two pipeline stages.
  assign b_ready     = !b_vld_q || out_if.ready;
  assign in_if.ready = !a_vld_q || b_ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign a_load      = a_vld_q && b_ready;

  tbpw_pos_ctr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .step_i  (in_fire),
    .col_o   (pos_col),
    .row_o   (pos_row),
    .chan_o  (pos_chan),
    .last_o  (pos_last),
    .width_o (w_eff)
  );

  // Input register: element plus its position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      a_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_raw_q  <= in_if.raw_element;
      a_col_q  <= pos_col;
      a_row_q  <= pos_row;
      a_chan_q <= pos_chan;
      a_last_q <= pos_last;
    end
  end

  tbpw_byte_cvt u_cvt (
    .elem_type_i (cfg_q.element_type),
    .raw_i       (a_raw_q),
    .byte_o      (cvt_byte)
  );

  // Byte address in the interleaved BGR image.
  always_comb begin
    pix_idx   = SW'(a_row_q) * SW'(w_eff) + SW'(a_col_q);
    addr_full = (pix_idx << 1) + pix_idx + SW'(2'd2 - a_chan_q);
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_ready) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      b_data_q.byte_address <= addr_full[ADDR_W-1:0];
      b_data_q.pixel_byte   <= cvt_byte;
      b_data_q.frame_end    <= a_last_q;
    end
  end

  assign out_if.valid = b_vld_q;
  assign out_if.data  = b_data_q;

  // An accepted element is held in the input register next cycle.
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> a_vld_q)
    else $error("accepted element not held in input register");

  // A stalled result is not dropped.
  a_res_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && !out_if.ready) |=> b_vld_q)
    else $error("stalled result lost");

  // Int8 elements never produce a byte with the top bit set.
  a_int8_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && cfg_q.element_type == ET_INT8 && $stable(cfg_q.element_type)
     && $past(a_load)) |-> !b_data_q.pixel_byte[7])
    else $error("int8 result not clamped");

endmodule
